>>> src/alp_pkg.sv
// ----------------------------------------------------------------------------
// alp_pkg: shared definitions for the address lease pool
// Table depth, request kinds, lease states, sequencer steps and the
// microcode control store.
// ----------------------------------------------------------------------------
package alp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_OFFER   = 2'd1;
    localparam logic [1:0] KIND_ACQUIRE = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    localparam logic [1:0] LS_FREE     = 2'd0;
    localparam logic [1:0] LS_OFFERED  = 2'd1;
    localparam logic [1:0] LS_ACQUIRED = 2'd2;
    localparam logic [1:0] LS_RELEASED = 2'd3;

    typedef logic [2:0] t_step;
    typedef logic [2:0] t_op;

    localparam t_step S_IDLE     = 3'd0;
    localparam t_step S_ADD_SCAN = 3'd1;
    localparam t_step S_ADD_PUT  = 3'd2;
    localparam t_step S_OFFER    = 3'd3;
    localparam t_step S_FIND     = 3'd4;
    localparam t_step S_PASS     = 3'd5;
    localparam t_step S_FAIL     = 3'd6;

    localparam t_op OP_WAIT       = 3'd0;
    localparam t_op OP_ADD_SCAN   = 3'd1;
    localparam t_op OP_ADD_PUT    = 3'd2;
    localparam t_op OP_OFFER_SCAN = 3'd3;
    localparam t_op OP_FIND_SCAN  = 3'd4;
    localparam t_op OP_RESP_OK    = 3'd5;
    localparam t_op OP_RESP_FAIL  = 3'd6;

    typedef struct packed {
        t_op   op;
        t_step go_hit;
        t_step go_end;
    } t_uword;

    function automatic t_uword f_ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_IDLE:     w = '{op: OP_WAIT,       go_hit: S_IDLE, go_end: S_IDLE};
            S_ADD_SCAN: w = '{op: OP_ADD_SCAN,   go_hit: S_FAIL, go_end: S_ADD_PUT};
            S_ADD_PUT:  w = '{op: OP_ADD_PUT,    go_hit: S_PASS, go_end: S_FAIL};
            S_OFFER:    w = '{op: OP_OFFER_SCAN, go_hit: S_PASS, go_end: S_FAIL};
            S_FIND:     w = '{op: OP_FIND_SCAN,  go_hit: S_PASS, go_end: S_FAIL};
            S_PASS:     w = '{op: OP_RESP_OK,    go_hit: S_IDLE, go_end: S_IDLE};
            S_FAIL:     w = '{op: OP_RESP_FAIL,  go_hit: S_IDLE, go_end: S_IDLE};
            default:    w = '{op: OP_WAIT,       go_hit: S_IDLE, go_end: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> src/address_lease_pool_unit.sv
// ----------------------------------------------------------------------------
// address_lease_pool_unit: lease table with a microcoded scan sequencer
// Add, offer, acquire and release requests over a table of address entries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe o_done rises, and a new request may be issued in
// that same cycle. The sequencer walks the valid entries one per cycle; an
// offer, acquire or release stops at the first matching entry, and an add
// scans every valid entry for a duplicate before it writes back. Each
// result is shown for exactly one cycle on o_done; the receiver cannot stall
// it. The table is empty after reset; valid entries are tracked by a fill
// count, so no clearing pass is needed.
module address_lease_pool_unit
    import alp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [47:0] i_client_mac,
    input  logic [31:0] i_address,
    output logic        o_done,
    output logic        o_ok,
    output logic [31:0] o_offered_address
);

    logic [31:0] r_entry_address [POOL_DEPTH];
    logic [47:0] r_entry_mac     [POOL_DEPTH];
    logic [1:0]  r_entry_state   [POOL_DEPTH];

    t_step            r_step, n_step;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [1:0]       r_kind, n_kind;
    logic [47:0]      r_mac, n_mac;
    logic [31:0]      r_ip, n_ip;
    logic [31:0]      r_ip_out, n_ip_out;
    logic             r_done, n_done;
    logic             r_ok, n_ok;
    logic [31:0]      r_offered, n_offered;

    t_uword           uw;
    logic [IDX_W-1:0] pos_idx;
    logic [31:0]      e_addr;
    logic [47:0]      e_mac;
    logic [1:0]       e_state;
    logic             at_end;
    logic             mac_hit;
    logic             hit;

    logic             wr_new;
    logic             wr_state;
    logic             wr_mac;
    logic [IDX_W-1:0] wr_idx;
    logic [1:0]       wr_state_val;

    assign uw      = f_ucode(r_step);
    assign pos_idx = r_pos[IDX_W-1:0];
    assign e_addr  = r_entry_address[pos_idx];
    assign e_mac   = r_entry_mac[pos_idx];
    assign e_state = r_entry_state[pos_idx];
    assign at_end  = (r_pos >= r_count);
    assign mac_hit = (e_mac == r_mac);

    always_comb begin
        unique case (uw.op)
            OP_ADD_SCAN:   hit = (e_addr == r_ip) || mac_hit;
            OP_ADD_PUT:    hit = (r_count != CNT_W'(POOL_DEPTH));
            OP_OFFER_SCAN: hit = (((e_state == LS_ACQUIRED) || (e_state == LS_OFFERED))
                                  && mac_hit)
                                 || (e_state == LS_FREE) || (e_state == LS_RELEASED);
            OP_FIND_SCAN:  hit = mac_hit;
            default:       hit = 1'b0;
        endcase
    end

    always_comb begin
        n_step       = r_step;
        n_count      = r_count;
        n_pos        = r_pos;
        n_kind       = r_kind;
        n_mac        = r_mac;
        n_ip         = r_ip;
        n_ip_out     = r_ip_out;
        n_done       = 1'b0;
        n_ok         = r_ok;
        n_offered    = r_offered;
        wr_new       = 1'b0;
        wr_state     = 1'b0;
        wr_mac       = 1'b0;
        wr_idx       = pos_idx;
        wr_state_val = LS_OFFERED;

        unique case (uw.op)
            OP_WAIT: begin
                if (start) begin
                    n_kind   = i_kind;
                    n_mac    = i_client_mac;
                    n_ip     = i_address;
                    n_ip_out = '0;
                    n_pos    = '0;
                    unique case (i_kind) inside
                        KIND_ADD:                   n_step = S_ADD_SCAN;
                        KIND_OFFER:                 n_step = S_OFFER;
                        KIND_ACQUIRE, KIND_RELEASE: n_step = S_FIND;
                        default:                    n_step = S_FIND;
                    endcase
                end
            end
            OP_ADD_PUT: begin
                wr_idx = r_count[IDX_W-1:0];
                if (hit) begin
                    wr_new  = 1'b1;
                    n_count = r_count + 1'b1;
                    n_step  = uw.go_hit;
                end else begin
                    n_step = uw.go_end;
                end
            end
            OP_ADD_SCAN, OP_OFFER_SCAN, OP_FIND_SCAN: begin
                if (at_end) begin
                    n_step = uw.go_end;
                end else if (hit) begin
                    n_step = uw.go_hit;
                    if (uw.op == OP_OFFER_SCAN) begin
                        wr_state     = 1'b1;
                        wr_mac       = 1'b1;
                        wr_state_val = LS_OFFERED;
                        n_ip_out     = e_addr;
                    end else if (uw.op == OP_FIND_SCAN) begin
                        wr_state     = 1'b1;
                        wr_state_val = (r_kind == KIND_ACQUIRE) ? LS_ACQUIRED : LS_RELEASED;
                    end
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            OP_RESP_OK: begin
                n_done    = 1'b1;
                n_ok      = 1'b1;
                n_offered = r_ip_out;
                n_step    = uw.go_hit;
            end
            OP_RESP_FAIL: begin
                n_done    = 1'b1;
                n_ok      = 1'b0;
                n_offered = '0;
                n_step    = uw.go_hit;
            end
            default: begin
                n_step = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_count <= n_count;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_mac     <= n_mac;
        r_ip      <= n_ip;
        r_ip_out  <= n_ip_out;
        r_ok      <= n_ok;
        r_offered <= n_offered;
    end

    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            r_entry_address[wr_idx] <= r_ip;
            r_entry_mac[wr_idx]     <= r_mac;
            r_entry_state[wr_idx]   <= LS_FREE;
        end else begin
            if (wr_state) begin
                r_entry_state[wr_idx] <= wr_state_val;
            end
            if (wr_mac) begin
                r_entry_mac[wr_idx] <= r_mac;
            end
        end
    end

    assign busy              = (r_step != S_IDLE);
    assign o_done            = r_done;
    assign o_ok              = r_ok;
    assign o_offered_address = r_offered;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POOL_DEPTH))
        else $error("fill count exceeds table depth");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_count)
        else $error("scan position past fill count");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted request did not start the sequencer");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_offered_address == 32'd0))
        else $error("failed request carries an address");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_step) == S_ADD_PUT))
        else $error("fill count changed outside add write-back");
`endif

endmodule
